FILE: design/dts_pkg.sv
`default_nettype none
package dts_pkg;

    typedef enum logic [1:0] {
        OP_SCHED    = 2'd0,
        OP_CANCEL   = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [2:0] PRIO_NORMAL = 3'd2;
    localparam logic [2:0] PRIO_MAX    = 3'd4;

    localparam logic [2:0] CFG_FRAME = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN2,
        S_FINISH,
        S_OUT
    } t_state;

    // payload of one table entry
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] deadline;
        logic [2:0]  prio;
    } t_entry;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/dts_mem.sv
`default_nettype none
// Entry store: one write port, one registered read port.
module dts_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int HW    = 16
) (
    input  wire                    i_clk,
    input  wire                    i_we,
    input  wire  [AW-1:0]          i_waddr,
    input  wire  dts_pkg::t_entry  i_wentry,
    input  wire  [HW-1:0]          i_whandle,
    input  wire  [AW-1:0]          i_raddr,
    output dts_pkg::t_entry        o_rentry,
    output logic [HW-1:0]          o_rhandle
);
    dts_pkg::t_entry r_ent [DEPTH];
    logic [HW-1:0]   r_hnd [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_ent[i_waddr] <= i_wentry;
            r_hnd[i_waddr] <= i_whandle;
        end
        o_rentry  <= r_ent[i_raddr];
        o_rhandle <= r_hnd[i_raddr];
    end
endmodule
`default_nettype wire

FILE: design/deadline_task_scheduler_core.sv
`default_nettype none
// Deadline task scheduler. Task entries live in a single-port-read memory;
// live/ready flags are flip-flops. Every item sweeps the table through the
// memory read port, one entry per cycle; the read data is registered. One
// sweep serves most items. A dispatch that hands out a task needs a second
// sweep to find the next ready task and the earliest timer. Results sit in an
// output register and the input stalls until the result is delivered, so a
// stall on the result side holds off the next item.
module deadline_task_scheduler_core #(
    parameter int TASK_SLOTS  = 32,
    parameter int HANDLE_BITS = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [2:0]             i_cfg_index,
    input  wire  [30:0]            i_cfg_data,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire  [1:0]             i_op,
    input  wire  [2:0]             i_priority_req,
    input  wire  [30:0]            i_delay,
    input  wire  [30:0]            i_timeout_override,
    input  wire  [HANDLE_BITS-1:0] i_task_handle,
    input  wire  [31:0]            i_now,
    input  wire  [31:0]            i_slice_start,
    input  wire                    i_paint_pending,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic [1:0]             o_status,
    output logic [HANDLE_BITS-1:0] o_handle,
    output logic                   o_dispatched,
    output logic [2:0]             o_dispatched_priority,
    output logic                   o_did_timeout,
    output logic                   o_more_work,
    output logic                   o_callback_requested,
    output logic                   o_timer_armed,
    output logic [31:0]            o_timer_delay
);
    localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = AW + 1;
    localparam int HW = HANDLE_BITS;

    // configuration
    logic [30:0] r_tmo [5];
    logic [9:0]  r_frame;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tmo[0] <= 31'd0;
            r_tmo[1] <= 31'd250;
            r_tmo[2] <= 31'd5000;
            r_tmo[3] <= 31'd10000;
            r_tmo[4] <= 31'd1073741823;
            r_frame  <= 10'd5;
        end else if (i_cfg_we) begin
            if (i_cfg_index < dts_pkg::CFG_FRAME)
                r_tmo[i_cfg_index] <= i_cfg_data;
            else if (i_cfg_index == dts_pkg::CFG_FRAME)
                r_frame <= i_cfg_data[9:0];
        end
    end

    // control state
    dts_pkg::t_state r_state, n_state;
    logic [TASK_SLOTS-1:0] r_live, r_ready;
    logic [HW-1:0] r_next_h;
    logic r_cb_armed, r_to_armed;
    logic [CW-1:0] r_cnt;

    // latched item
    dts_pkg::t_op r_op;
    logic [31:0]  r_start, r_now, r_ss;
    logic [HW-1:0] r_th;
    logic r_paint;

    // scan accumulators
    logic          r_rv;         // read data valid for slot r_rslot
    logic [AW-1:0] r_rslot;
    logic          r_bt_ok, r_br_ok, r_bt2_ok, r_fnd_ok;
    logic [AW-1:0] r_bt, r_br, r_fnd;
    logic [31:0]   r_bt_key, r_br_key;
    logic [HW-1:0] r_bt_age, r_br_age;
    logic [2:0]    r_br_pr;
    logic [HW-1:0] r_br_h;

    // memory
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    dts_pkg::t_entry mem_wentry, mem_rentry;
    logic [HW-1:0] mem_rhandle;

    dts_mem #(.DEPTH(TASK_SLOTS), .AW(AW), .HW(HW)) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wentry (mem_wentry),
        .i_whandle(r_next_h),
        .i_raddr  (mem_raddr),
        .o_rentry (mem_rentry),
        .o_rhandle(mem_rhandle)
    );

    // free slot: lowest non-live
    logic          free_ok;
    logic [AW-1:0] free_slot;
    always_comb begin
        free_ok = 1'b0;
        free_slot = '0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
            if (!r_live[i]) begin
                free_ok = 1'b1;
                free_slot = AW'(i);
            end
        end
    end

    wire in_acc  = i_valid && !o_stall;
    wire out_acc = o_valid && !i_stall;
    assign o_stall = (r_state != dts_pkg::S_IDLE);

    // item decode
    logic [2:0]  in_pr;
    logic [31:0] in_start, in_dl, in_tmo;
    always_comb begin
        in_pr = (i_priority_req > dts_pkg::PRIO_MAX) ? dts_pkg::PRIO_NORMAL : i_priority_req;
        in_start = dts_pkg::sat_add(i_now, {1'b0, i_delay});
        in_tmo = (i_timeout_override != '0) ? {1'b0, i_timeout_override}
                                            : {1'b0, r_tmo[in_pr]};
        in_dl = dts_pkg::sat_add(in_start, in_tmo);
    end

    assign mem_we     = in_acc && (i_op == dts_pkg::OP_SCHED) && free_ok;
    assign mem_waddr  = free_slot;
    assign mem_wentry = '{start: in_start, deadline: in_dl, prio: in_pr};
    assign mem_raddr  = r_cnt[AW-1:0];

    // current sweep entry
    wire [HW-1:0] cur_age  = mem_rhandle - r_next_h;
    wire cur_live  = r_live[r_rslot];
    wire cur_ready = r_ready[r_rslot] ||
                     (r_op == dts_pkg::OP_DISPATCH && r_state == dts_pkg::S_SCAN &&
                      mem_rentry.start <= r_now);
    wire cur_t = r_rv && cur_live && !cur_ready;
    wire cur_r = r_rv && cur_live && cur_ready && !(r_state == dts_pkg::S_SCAN2 && r_rslot == r_br);
    wire t_better = !r_bt_ok || mem_rentry.start < r_bt_key ||
                    (mem_rentry.start == r_bt_key && cur_age < r_bt_age);
    wire r_better = !r_br_ok || mem_rentry.deadline < r_br_key ||
                    (mem_rentry.deadline == r_br_key && cur_age < r_br_age);
    // all reads issued; sweep ends once the last read data is gone
    wire cnt_done = (r_cnt == CW'(TASK_SLOTS));
    wire sweep_end = cnt_done && !r_rv;

    // yield test on the earliest ready task
    wire [31:0] elapsed = (r_ss > r_now) ? 32'd0 : r_now - r_ss;
    wire r_yield_w = (r_br_key > r_now) && (r_paint || elapsed >= {22'd0, r_frame});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dts_pkg::S_IDLE:   if (in_acc) n_state = dts_pkg::S_SCAN;
            dts_pkg::S_SCAN: begin
                if (sweep_end)
                    n_state = (r_op == dts_pkg::OP_DISPATCH && r_br_ok && !r_yield_w) ?
                              dts_pkg::S_SCAN2 : dts_pkg::S_FINISH;
            end
            dts_pkg::S_SCAN2:  if (sweep_end) n_state = dts_pkg::S_FINISH;
            dts_pkg::S_FINISH: n_state = dts_pkg::S_OUT;
            dts_pkg::S_OUT:    if (out_acc) n_state = dts_pkg::S_IDLE;
            default:           n_state = dts_pkg::S_IDLE;
        endcase
    end

    always_comb o_valid = (r_state == dts_pkg::S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dts_pkg::S_IDLE;
            r_live     <= '0;
            r_ready    <= '0;
            r_next_h   <= HW'(1);
            r_cb_armed <= 1'b0;
            r_to_armed <= 1'b0;
            r_cnt      <= '0;
            r_rv       <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                dts_pkg::S_IDLE: begin
                    r_cnt <= '0;
                    r_rv  <= 1'b0;
                    if (in_acc) begin
                        r_op <= dts_pkg::t_op'(i_op);
                        r_start <= in_start;
                        r_now <= i_now;
                        r_ss <= i_slice_start;
                        r_th <= i_task_handle;
                        r_paint <= i_paint_pending;
                        r_bt_ok <= 1'b0; r_br_ok <= 1'b0; r_fnd_ok <= 1'b0;
                        r_bt2_ok <= free_ok;
                        r_fnd <= free_slot;
                        if (mem_we) begin
                            r_live[free_slot] <= 1'b1;
                            r_ready[free_slot] <= 1'b0;
                            r_next_h <= (r_next_h + HW'(1) == '0) ? HW'(1) : r_next_h + HW'(1);
                        end
                        if (i_op == dts_pkg::OP_DISPATCH) begin
                            r_cb_armed <= 1'b0;
                            r_to_armed <= 1'b0;
                        end
                    end
                end
                dts_pkg::S_SCAN, dts_pkg::S_SCAN2: begin
                    // one read per cycle; its data arrives in the following cycle for r_rslot
                    r_rv <= !cnt_done;
                    if (!cnt_done) begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_rslot <= r_cnt[AW-1:0];
                    end
                    if (r_state == dts_pkg::S_SCAN && n_state == dts_pkg::S_SCAN2) begin
                        r_cnt <= '0; r_bt_ok <= 1'b0;
                        r_live[r_br] <= 1'b0; r_ready[r_br] <= 1'b0;
                    end
                    if (r_rv) begin
                        if (r_state == dts_pkg::S_SCAN && r_op == dts_pkg::OP_DISPATCH && cur_live)
                            r_ready[r_rslot] <= cur_ready;
                        if (cur_t && t_better) begin
                            r_bt_ok <= 1'b1; r_bt <= r_rslot;
                            r_bt_key <= mem_rentry.start; r_bt_age <= cur_age;
                        end
                        if (r_state == dts_pkg::S_SCAN) begin
                            if (cur_r && r_better) begin
                                r_br_ok <= 1'b1; r_br <= r_rslot;
                                r_br_key <= mem_rentry.deadline; r_br_age <= cur_age;
                                r_br_pr <= mem_rentry.prio; r_br_h <= mem_rhandle;
                            end
                            if (r_op == dts_pkg::OP_CANCEL && cur_live && !r_fnd_ok &&
                                mem_rhandle == r_th) begin
                                r_fnd_ok <= 1'b1; r_fnd <= r_rslot;
                            end
                        end else if (cur_r) begin
                            r_fnd_ok <= 1'b1;
                        end
                    end
                end
                dts_pkg::S_FINISH: begin
                    r_cnt <= '0;
                    o_status <= dts_pkg::ST_OK; o_handle <= '0; o_dispatched <= 1'b0;
                    o_dispatched_priority <= '0; o_did_timeout <= 1'b0; o_more_work <= 1'b0;
                    o_callback_requested <= 1'b0; o_timer_armed <= 1'b0; o_timer_delay <= '0;
                    case (r_op)
                        dts_pkg::OP_SCHED: begin
                            if (!r_bt2_ok) o_status <= dts_pkg::ST_FULL;
                            else begin
                                o_handle <= r_next_h - HW'(1) == '0 ? {HW{1'b1}} : r_next_h - HW'(1);
                                if (r_start > r_now) begin
                                    if (!r_br_ok && r_bt_ok && r_bt == r_fnd) begin
                                        r_to_armed <= 1'b1; o_timer_armed <= 1'b1;
                                        o_timer_delay <= r_start - r_now;
                                    end
                                end else begin
                                    r_ready[r_fnd] <= 1'b1;
                                    if (!r_cb_armed) begin
                                        r_cb_armed <= 1'b1; o_callback_requested <= 1'b1;
                                    end
                                end
                            end
                        end
                        dts_pkg::OP_CANCEL: begin
                            o_handle <= r_th;
                            if (r_th != '0) begin
                                if (!r_fnd_ok) o_status <= dts_pkg::ST_NOT_FOUND;
                                else begin
                                    r_live[r_fnd] <= 1'b0; r_ready[r_fnd] <= 1'b0;
                                end
                            end
                        end
                        dts_pkg::OP_DISPATCH: begin
                            if (r_br_ok && r_yield_w) begin
                                o_more_work <= 1'b1; o_callback_requested <= 1'b1;
                                r_cb_armed <= 1'b1;
                            end else begin
                                if (r_br_ok) begin
                                    o_handle <= r_br_h; o_dispatched <= 1'b1;
                                    o_dispatched_priority <= r_br_pr;
                                    o_did_timeout <= (r_br_key <= r_now);
                                end
                                if (r_br_ok && r_fnd_ok) begin
                                    o_more_work <= 1'b1; o_callback_requested <= 1'b1;
                                    r_cb_armed <= 1'b1;
                                end else if (r_bt_ok) begin
                                    r_to_armed <= 1'b1; o_timer_armed <= 1'b1;
                                    o_timer_delay <= r_bt_key - r_now;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: design/dts_checker.sv
`default_nettype none
module dts_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_stall,
    input wire        o_valid,
    input wire        i_stall,
    input wire [1:0]  o_status,
    input wire        o_dispatched,
    input wire        o_did_timeout,
    input wire        o_more_work,
    input wire        o_callback_requested,
    input wire        o_timer_armed,
    input wire [31:0] o_timer_delay
);
    a_more_cb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_more_work |-> o_callback_requested)
        else $error("more work without callback");
    a_timer_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_timer_armed |-> o_timer_delay == 32'd0)
        else $error("timer delay without timer");
    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_did_timeout |-> o_dispatched)
        else $error("timeout flag without dispatch");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("result changed under stall");
    // an offered item stays offered until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid)
        else $error("input item dropped while stalled");
endmodule

bind deadline_task_scheduler_core dts_checker u_chk (.*);
`default_nettype wire
